// ----- rtl/fsp_pkg.sv -----
// Shared types, constants and helper functions of the format specification parser.
`timescale 1ns / 1ps
`default_nettype none

package fsp_pkg;

  // Magnitude bits of the width and precision counters.
  localparam int COUNT_BITS = 16;
  localparam int CNT_W      = COUNT_BITS + 1;
  localparam int CH_W       = 8;
  localparam int STAR_W     = 17;
  localparam int FLAG_W     = 5;
  localparam int QUAL_W     = 9;

  // Working width for star arguments: room for the magnitude of the most negative value.
  localparam int WK = ((CNT_W > STAR_W) ? CNT_W : STAR_W) + 1;

  localparam longint CNT_MAX_L = (longint'(1) << COUNT_BITS) - 1;
  localparam logic [CNT_W-1:0]      CNT_MAX  = CNT_W'(CNT_MAX_L);
  localparam logic signed [WK-1:0]  CLAMP_HI = WK'(CNT_MAX_L);
  localparam logic signed [WK-1:0]  CLAMP_LO = WK'(-CNT_MAX_L);

  // Digit accumulator: wide enough for ten times the largest count plus nine.
  localparam int ACC_W = COUNT_BITS + 5;

  // Stream word widths, rounded up to whole bytes.
  localparam int IN_BITS     = CH_W + STAR_W;
  localparam int IN_TDATA_W  = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_BITS    = FLAG_W + 2 * CNT_W + QUAL_W + CH_W;
  localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

  // Characters of interest.
  localparam logic [CH_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [CH_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [CH_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CH_W-1:0] CH_HASH  = 8'h23;
  localparam logic [CH_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CH_W-1:0] CH_NINE  = 8'h39;
  localparam logic [CH_W-1:0] CH_STAR  = 8'h2A;
  localparam logic [CH_W-1:0] CH_DOT   = 8'h2E;
  localparam logic [CH_W-1:0] CH_H     = 8'h68;
  localparam logic [CH_W-1:0] CH_L     = 8'h6C;
  localparam logic [CH_W-1:0] CH_J     = 8'h6A;
  localparam logic [CH_W-1:0] CH_Z     = 8'h7A;

  // Flag bits.
  localparam logic [FLAG_W-1:0] F_LEFT  = 5'b00001;
  localparam logic [FLAG_W-1:0] F_PLUS  = 5'b00010;
  localparam logic [FLAG_W-1:0] F_SPACE = 5'b00100;
  localparam logic [FLAG_W-1:0] F_ALT   = 5'b01000;
  localparam logic [FLAG_W-1:0] F_ZERO  = 5'b10000;

  localparam logic [QUAL_W-1:0] QUAL_TOGGLE = 9'h020;
  localparam logic [QUAL_W-1:0] QUAL_NONE   = '1;
  localparam logic [CNT_W-1:0]  CNT_NONE    = '1;

  typedef enum logic [5:0] {
    PH_FLAG  = 6'b000001,
    PH_WSTAR = 6'b000010,
    PH_WDIG  = 6'b000100,
    PH_DOT   = 6'b001000,
    PH_PDIG  = 6'b010000,
    PH_QUAL  = 6'b100000
  } phase_t;

  typedef struct packed {
    phase_t              phase;
    logic [FLAG_W-1:0]   flags;
    logic [CNT_W-1:0]    width;
    logic [CNT_W-1:0]    prec;
    logic [QUAL_W-1:0]   qual;
  } state_t;

  typedef struct packed {
    logic [FLAG_W-1:0]   flags;
    logic [CNT_W-1:0]    width;
    logic [CNT_W-1:0]    prec;
    logic [QUAL_W-1:0]   qual;
    logic [CH_W-1:0]     stop;
  } result_t;

  localparam state_t STATE_CLEAR = '{
    phase: PH_FLAG,
    flags: '0,
    width: CNT_NONE,
    prec:  CNT_NONE,
    qual:  QUAL_NONE
  };

  function automatic logic [FLAG_W-1:0] flag_of(input logic [CH_W-1:0] c);
    logic [FLAG_W-1:0] f;
    unique case (c)
      CH_MINUS: f = F_LEFT;
      CH_PLUS:  f = F_PLUS;
      CH_SPACE: f = F_SPACE;
      CH_HASH:  f = F_ALT;
      CH_ZERO:  f = F_ZERO;
      default:  f = '0;
    endcase
    return f;
  endfunction

  function automatic logic is_digit(input logic [CH_W-1:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  function automatic logic is_qual(input logic [CH_W-1:0] c);
    return (c == CH_H) || (c == CH_L) || (c == CH_J) || (c == CH_Z);
  endfunction

  // Appends one decimal digit; a negative accumulator counts as zero. Saturates.
  function automatic logic [CNT_W-1:0] push_digit(input logic [CNT_W-1:0] acc,
                                                  input logic [CH_W-1:0]  c);
    logic [ACC_W-1:0] base;
    logic [ACC_W-1:0] sum;
    base = acc[CNT_W-1] ? '0 : ACC_W'(acc[COUNT_BITS-1:0]);
    sum  = (base << 3) + (base << 1) + ACC_W'(c[3:0]);
    if (sum > ACC_W'(CNT_MAX_L)) begin
      return CNT_MAX;
    end
    return sum[CNT_W-1:0];
  endfunction

  // Limits a signed value to the counter magnitude.
  function automatic logic [CNT_W-1:0] clamp_mag(input logic signed [WK-1:0] v);
    if (v > CLAMP_HI) begin
      return CLAMP_HI[CNT_W-1:0];
    end
    if (v < CLAMP_LO) begin
      return CLAMP_LO[CNT_W-1:0];
    end
    return v[CNT_W-1:0];
  endfunction

endpackage

`default_nettype wire

// ----- rtl/format_spec_parser.sv -----
// Top level of the printf-style conversion specification parser.
`timescale 1ns / 1ps
`default_nettype none

// The parser takes the characters of one conversion specification, starting
// after the percent sign, one word per character on the in_ channel. A word
// carries the character and, for a star, the signed argument it consumes.
// Flags, width, precision and length qualifier are gathered as the characters
// arrive; the first character that fits no open phase ends the specification
// and produces one out_ word with the gathered fields and that character.
// Characters that are absorbed produce no word at all.
// An accepted character waits in the input register, is decoded there against
// the parser state, and its result word is registered in the result register
// and presented on out_tvalid. Throughput is one character per cycle unless
// a second result meets a stalled receiver: the whole decode, including the
// times-ten digit accumulate, sits between the input register and the result
// register, and the parser state is updated once per character.
// When the receiver stalls, a finished word waits in the result register while
// characters that produce no result keep flowing; only a character that would
// produce a second result holds in the input register, and in_tready drops.
// Reset (rst_n low, synchronous) empties both registers and returns the
// parser to the flag phase with width, precision and qualifier not given.
module format_spec_parser (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // in_tdata, lowest bit up: ch (8), star_value (17), zero fill
  input  logic [fsp_pkg::IN_TDATA_W-1:0]    in_tdata,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // out_tdata, lowest bit up: flag_bits (5), width (17), precision (17),
  // qualifier (9), stop_char (8)
  output logic [fsp_pkg::OUT_TDATA_W-1:0]   out_tdata
);
  import fsp_pkg::*;

  // Input register.
  logic                      s1_valid_r;
  logic                      s1_valid_nxt;
  logic [CH_W-1:0]           s1_ch_r;
  logic signed [STAR_W-1:0]  s1_sv_r;

  // Parser state.
  state_t                    st_r;
  state_t                    st_step;

  // Result register.
  logic                      out_valid_r;
  logic                      out_valid_nxt;
  result_t                   out_res_r;
  result_t                   res_step;

  logic                      emit;
  logic                      fire;
  logic                      in_acc;

  fsp_step u_step (
    .cur        (st_r),
    .ch         (s1_ch_r),
    .star_value (s1_sv_r),
    .nxt        (st_step),
    .emit       (emit),
    .res        (res_step)
  );

  // A buffered character proceeds unless it makes a result and the result
  // register is full and not being drained this cycle.
  assign fire      = s1_valid_r && (!emit || !out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || fire;
  assign in_acc    = in_tvalid && in_tready;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_acc) begin
      s1_valid_nxt = 1'b1;
    end else if (fire) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (fire && emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      st_r        <= STATE_CLEAR;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (fire) begin
        st_r <= st_step;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_ch_r <= in_tdata[CH_W-1:0];
      s1_sv_r <= in_tdata[CH_W+STAR_W-1:CH_W];
    end
    if (fire && emit) begin
      out_res_r <= res_step;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_TDATA_W'({out_res_r.stop, out_res_r.qual, out_res_r.prec,
                                    out_res_r.width, out_res_r.flags});

`ifndef SYNTHESIS
  // A finished specification leaves the parser cleared for the next one.
  assert property (@(posedge clk) disable iff (!rst_n)
    fire && emit |=> (st_r.phase == PH_FLAG) && (st_r.flags == '0) &&
                     (st_r.width == CNT_NONE) && (st_r.prec == CNT_NONE) &&
                     (st_r.qual == QUAL_NONE))
    else $error("parser state not cleared after a result");

  // The width is either not given or a non-negative count.
  assert property (@(posedge clk) disable iff (!rst_n)
    !st_r.width[CNT_W-1] || (st_r.width == CNT_NONE))
    else $error("width accumulator holds a negative count");

  // Backpressure only comes from a waiting result and a full input register.
  assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> s1_valid_r && out_valid_r && !out_tready && emit)
    else $error("input stalled without cause");

  // A new result appears only from a character that ended a specification.
  assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(fire && emit))
    else $error("result word without a stopping character");
`endif

endmodule

`default_nettype wire

// ----- rtl/fsp_step.sv -----
// Next-state and result logic for one specification character.
`timescale 1ns / 1ps
`default_nettype none

module fsp_step (
  input  fsp_pkg::state_t                   cur,
  input  logic [fsp_pkg::CH_W-1:0]          ch,
  input  logic signed [fsp_pkg::STAR_W-1:0] star_value,
  output fsp_pkg::state_t                   nxt,
  output logic                              emit,
  output fsp_pkg::result_t                  res
);
  import fsp_pkg::*;

  logic [FLAG_W-1:0]      fl;
  logic                   digit;
  logic                   early;
  logic signed [WK-1:0]   svx;
  logic signed [WK-1:0]   svmag;

  assign fl    = flag_of(ch);
  assign digit = is_digit(ch);
  assign early = (cur.phase == PH_FLAG) || (cur.phase == PH_WSTAR) || (cur.phase == PH_WDIG);
  assign svx   = WK'(star_value);
  assign svmag = svx[WK-1] ? -svx : svx;

  always_comb begin
    nxt  = cur;
    emit = 1'b0;
    res  = '{flags: cur.flags, width: cur.width, prec: cur.prec, qual: cur.qual, stop: ch};
    priority if ((cur.phase == PH_FLAG) && (fl != '0)) begin
      nxt.flags = cur.flags | fl;
    end else if (early && (ch == CH_STAR)) begin
      if (svx[WK-1]) begin
        nxt.flags = cur.flags | F_LEFT;
      end
      nxt.width = clamp_mag(svmag);
      nxt.phase = PH_WSTAR;
    end else if (early && digit) begin
      nxt.width = push_digit((cur.phase == PH_WDIG) ? cur.width : '0, ch);
      nxt.phase = PH_WDIG;
    end else if (early && (ch == CH_DOT)) begin
      nxt.prec  = '0;
      nxt.phase = PH_DOT;
    end else if ((cur.phase == PH_DOT) && (ch == CH_STAR)) begin
      nxt.prec  = clamp_mag(svx);
      nxt.phase = PH_QUAL;
    end else if ((cur.phase == PH_DOT) && digit) begin
      nxt.prec  = push_digit('0, ch);
      nxt.phase = PH_PDIG;
    end else if ((cur.phase == PH_PDIG) && digit) begin
      nxt.prec  = push_digit(cur.prec, ch);
    end else if (is_qual(ch)) begin
      if (cur.qual[QUAL_W-1]) begin
        nxt.qual = {1'b0, ch};
      end else if ((ch == CH_H) || (ch == CH_L)) begin
        nxt.qual = cur.qual ^ QUAL_TOGGLE;
      end
      nxt.phase = PH_QUAL;
    end else begin
      emit = 1'b1;
      nxt  = STATE_CLEAR;
    end
  end

endmodule

`default_nettype wire
